// ===== sv/graph_bfs_dfs_traversal_macros.svh =====
// ----------------------------------------------------------------------------
// Graph traversal assertion macros
// Concurrent assertion helpers shared by the traversal RTL.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define GBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("graph traversal assertion failed");
// Next-cycle implication.
`define GBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("graph traversal assertion failed");
`else
`define GBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/gbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Graph traversal package
// Shared constants, command and status codes, and beat payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package gbt_pkg;
	localparam int MAX_VERTICES_DEF = 32;
	localparam int MAX_DEGREE_DEF   = 8;
	localparam int VTX_W            = 5;
	localparam int WALK_DEPTH       = 32;
	localparam int UW               = 8;
	localparam int VC_W             = 6;
	localparam logic [VC_W-1:0] VC_RESET = 6'd32;
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_BFS   = 2'd1,
		CMD_DFS   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_VISIT = 2'd0,
		ST_DONE  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [VTX_W-1:0] first_vertex;
		logic [VTX_W-1:0] second_vertex;
	} in_item_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		status_t          status;
		logic             last;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/gbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gbt_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/gbt_cmp.sv =====
// ----------------------------------------------------------------------------
// Shared compare unit
// Unsigned less-than used for every range, degree and scan bound check.
// ----------------------------------------------------------------------------
`default_nettype none
module gbt_cmp (
	input  wire logic [gbt_pkg::UW-1:0] op_a,
	input  wire logic [gbt_pkg::UW-1:0] op_b,
	output logic                        lt
);
	import gbt_pkg::*;
	logic [UW:0] diff;

	// The borrow out of a - b is set exactly when a < b.
	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign lt   = diff[UW];
endmodule
`default_nettype wire

// ===== sv/graph_bfs_dfs_traversal.sv =====
// ----------------------------------------------------------------------------
// Graph traversal engine
// Undirected graph store with breadth-first and depth-first walks.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the in_* channel (valid/ready). Add edge appends
// each endpoint to the other's neighbor list and returns one status beat.
// Clear empties every list and returns one status beat. A breadth-first or
// depth-first walk returns one beat per reached vertex in visit order, with
// last set on the final one. Rejected commands return a single status beat.
// The block takes one command at a time; in_ready is low until every beat
// of the current command has been handed to the output register.
// A walk scans neighbor entries one at a time; the single read port of the
// neighbor RAM and the one shared compare unit set that pace.
// Each result sits in a one-beat output register; while the receiver stalls,
// work continues until the next beat is ready, then the sequencer waits.
// After reset the lists are empty, vertex_count is 32 and out_valid is low.
// The APB port holds vertex_count at byte address 0; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
module graph_bfs_dfs_traversal #(
	parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
	parameter int MAX_DEGREE   = gbt_pkg::MAX_DEGREE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire gbt_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output gbt_pkg::out_item_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);
	import gbt_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int DEG_W = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(WALK_DEPTH);
	localparam int SCW   = SW + 1;

	typedef struct packed {
		logic [VTX_W-1:0] v;
		logic [DEG_W-1:0] i;
	} ent_t;

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_CHK_A   = 16'h0002,
		S_CHK_B   = 16'h0004,
		S_CHK_DA  = 16'h0008,
		S_CHK_DB  = 16'h0010,
		S_WR_A    = 16'h0020,
		S_WR_B    = 16'h0040,
		S_W_INIT  = 16'h0080,
		S_PUSHV   = 16'h0100,
		S_B_POP   = 16'h0200,
		S_B_SCAN  = 16'h0400,
		S_B_CHK   = 16'h0800,
		S_D_TOP   = 16'h1000,
		S_D_CHK   = 16'h2000,
		S_FIN     = 16'h4000,
		S_EMIT_ST = 16'h8000
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [VTX_W-1:0] a_q, b_q, v_q, nv_q, pend_q;
	status_t          st_q;
	logic [VC_W-1:0]  vc_q;
	logic [DEG_W-1:0] deg_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vis_q;
	ent_t             scr_q [WALK_DEPTH];
	logic [SCW-1:0]   head_q, tail_q, sp_q, n_q;
	logic [DEG_W-1:0] i_q;
	logic             pend_vld_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [UW-1:0]    cnt, op_a, op_b;
	logic             lt;
	logic [VW-1:0]    deg_idx;
	logic [DEG_W-1:0] deg_rd;
	logic [SW-1:0]    scr_ra;
	ent_t             top;
	logic [VTX_W-1:0] w;
	logic [VTX_W-1:0] ram_rdata_w;
	logic             vis_w, bchk_ok, dchk_ok;
	logic             ram_we;
	logic [AW-1:0]    ram_wa, ram_ra;
	logic [VTX_W-1:0] ram_wd;
	logic             scr_we;
	logic [SW-1:0]    scr_wa;
	ent_t             scr_wd;
	logic             out_free, emit;
	out_item_t        emit_item;
	logic             cfg_wr;

	function automatic logic [AW-1:0] mk_addr(input logic [VTX_W-1:0] v,
			input logic [DEG_W-1:0] i);
		return AW'(AW'(v) * AW'(MAX_DEGREE)) + AW'(i);
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VC_W){1'b0}}, vc_q} : 32'd0;

	// A count above capacity acts as the capacity.
	assign cnt = (UW'(vc_q) > UW'(MAX_VERTICES)) ? UW'(MAX_VERTICES) : UW'(vc_q);

	// Single read port into the degree counters.
	always_comb begin
		case (state_q)
			S_CHK_DB, S_WR_B: deg_idx = VW'(b_q);
			S_B_SCAN:         deg_idx = VW'(v_q);
			S_D_TOP:          deg_idx = VW'(top.v);
			default:          deg_idx = VW'(a_q);
		endcase
	end
	assign deg_rd = deg_q[deg_idx];

	// The scratch array is the queue of a breadth-first walk and the stack of
	// a depth-first walk.
	assign scr_ra = (state_q == S_D_TOP) ? SW'(sp_q - 1'b1) : head_q[SW-1:0];
	assign top    = scr_q[scr_ra];

	assign w     = ram_rdata_w;
	assign vis_w = vis_q[VW'(w)];

	// Operand selection for the shared compare unit.
	always_comb begin
		case (state_q)
			S_CHK_A: begin
				op_a = UW'(a_q);
				op_b = cnt;
			end
			S_CHK_B: begin
				op_a = UW'(b_q);
				op_b = cnt;
			end
			S_CHK_DA: begin
				op_a = UW'(deg_rd) + ((a_q == b_q) ? UW'(2) : UW'(1));
				op_b = UW'(MAX_DEGREE + 1);
			end
			S_CHK_DB: begin
				op_a = UW'(deg_rd) + UW'(1);
				op_b = UW'(MAX_DEGREE + 1);
			end
			S_B_SCAN: begin
				op_a = UW'(i_q);
				op_b = UW'(deg_rd);
			end
			S_D_TOP: begin
				op_a = UW'(top.i);
				op_b = UW'(deg_rd);
			end
			S_B_CHK, S_D_CHK: begin
				op_a = UW'(w);
				op_b = cnt;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	gbt_cmp u_cmp (
		.op_a (op_a),
		.op_b (op_b),
		.lt   (lt)
	);

	assign bchk_ok = lt && !vis_w && (tail_q < SCW'(WALK_DEPTH));
	assign dchk_ok = lt && !vis_w && (sp_q < SCW'(WALK_DEPTH)) && (n_q < SCW'(WALK_DEPTH));

	// Neighbor store.
	assign ram_we = (state_q == S_WR_A) || (state_q == S_WR_B);
	assign ram_wa = (state_q == S_WR_B) ? mk_addr(b_q, deg_rd) : mk_addr(a_q, deg_rd);
	assign ram_wd = (state_q == S_WR_B) ? a_q : b_q;
	assign ram_ra = (state_q == S_D_TOP) ? mk_addr(top.v, top.i) : mk_addr(v_q, i_q);

	gbt_ram #(
		.WIDTH (VTX_W),
		.DEPTH (DEPTH)
	) u_nbr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rdata_w)
	);

	// Scratch writes.
	always_comb begin
		scr_we = 1'b0;
		scr_wa = '0;
		scr_wd = '{v: a_q, i: '0};
		case (state_q)
			S_W_INIT: begin
				scr_we = 1'b1;
			end
			S_B_CHK: begin
				scr_we = bchk_ok;
				scr_wa = tail_q[SW-1:0];
				scr_wd = '{v: w, i: '0};
			end
			S_D_TOP: begin
				scr_we = (sp_q != '0) && lt;
				scr_wa = scr_ra;
				scr_wd = '{v: top.v, i: top.i + 1'b1};
			end
			S_D_CHK: begin
				scr_we = dchk_ok;
				scr_wa = sp_q[SW-1:0];
				scr_wd = '{v: w, i: '0};
			end
			default: begin
				scr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_q[scr_wa] <= scr_wd;
		end
	end

	// Result beats. A visit is held back until the next one is known, so the
	// final visit of a walk can carry last.
	assign out_free = !out_valid_q || out_ready;
	always_comb begin
		emit      = 1'b0;
		emit_item = '{vertex: pend_q, status: ST_VISIT, last: 1'b0};
		case (state_q)
			S_PUSHV: begin
				emit = pend_vld_q && out_free;
			end
			S_FIN: begin
				emit           = out_free;
				emit_item.last = 1'b1;
			end
			S_EMIT_ST: begin
				emit      = out_free;
				emit_item = '{vertex: '0, status: st_q, last: 1'b1};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vc_q        <= VC_RESET;
			vis_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			sp_q        <= '0;
			n_q         <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_VERTICES; k++) begin
				deg_q[k] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				vc_q <= pwdata[VC_W-1:0];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_data.cmd;
						a_q   <= in_data.first_vertex;
						b_q   <= in_data.second_vertex;
						if (in_data.cmd == CMD_CLEAR) begin
							for (int k = 0; k < MAX_VERTICES; k++) begin
								deg_q[k] <= '0;
							end
							st_q    <= ST_DONE;
							state_q <= S_EMIT_ST;
						end else begin
							state_q <= S_CHK_A;
						end
					end
				end
				S_CHK_A: begin
					if (!lt) begin
						st_q    <= ST_RANGE;
						state_q <= S_EMIT_ST;
					end else if (cmd_q == CMD_ADD) begin
						state_q <= S_CHK_B;
					end else begin
						state_q <= S_W_INIT;
					end
				end
				S_CHK_B: begin
					if (!lt) begin
						st_q    <= ST_RANGE;
						state_q <= S_EMIT_ST;
					end else begin
						state_q <= S_CHK_DA;
					end
				end
				S_CHK_DA: begin
					if (!lt) begin
						st_q    <= ST_FULL;
						state_q <= S_EMIT_ST;
					end else if (a_q == b_q) begin
						state_q <= S_WR_A;
					end else begin
						state_q <= S_CHK_DB;
					end
				end
				S_CHK_DB: begin
					if (!lt) begin
						st_q    <= ST_FULL;
						state_q <= S_EMIT_ST;
					end else begin
						state_q <= S_WR_A;
					end
				end
				S_WR_A: begin
					deg_q[deg_idx] <= deg_rd + 1'b1;
					state_q        <= S_WR_B;
				end
				S_WR_B: begin
					deg_q[deg_idx] <= deg_rd + 1'b1;
					st_q           <= ST_DONE;
					state_q        <= S_EMIT_ST;
				end
				S_W_INIT: begin
					// Only the source is marked at the start of a walk.
					vis_q             <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << VW'(a_q);
					head_q            <= '0;
					tail_q            <= SCW'(1);
					sp_q              <= SCW'(1);
					n_q               <= SCW'(1);
					pend_vld_q        <= 1'b0;
					nv_q              <= a_q;
					state_q           <= (cmd_q == CMD_BFS) ? S_B_POP : S_PUSHV;
				end
				S_PUSHV: begin
					if (!pend_vld_q || out_free) begin
						pend_q     <= nv_q;
						pend_vld_q <= 1'b1;
						i_q        <= '0;
						state_q    <= (cmd_q == CMD_BFS) ? S_B_SCAN : S_D_TOP;
					end
				end
				S_B_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_FIN;
					end else begin
						v_q     <= top.v;
						nv_q    <= top.v;
						head_q  <= head_q + 1'b1;
						state_q <= S_PUSHV;
					end
				end
				S_B_SCAN: begin
					state_q <= lt ? S_B_CHK : S_B_POP;
				end
				S_B_CHK: begin
					if (bchk_ok) begin
						vis_q[VW'(w)] <= 1'b1;
						tail_q        <= tail_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_B_SCAN;
				end
				S_D_TOP: begin
					if (sp_q == '0) begin
						state_q <= S_FIN;
					end else if (!lt) begin
						sp_q <= sp_q - 1'b1;
					end else begin
						state_q <= S_D_CHK;
					end
				end
				S_D_CHK: begin
					if (dchk_ok) begin
						vis_q[VW'(w)] <= 1'b1;
						n_q           <= n_q + 1'b1;
						sp_q          <= sp_q + 1'b1;
						nv_q          <= w;
						state_q       <= S_PUSHV;
					end else begin
						state_q <= S_D_TOP;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				S_EMIT_ST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "graph_bfs_dfs_traversal_macros.svh"

	`GBT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`GBT_ASSERT_IMP(a_status_beat_shape, clk, arst_n, out_valid_q && (out_q.status != ST_VISIT), out_q.last && (out_q.vertex == '0))
	`GBT_ASSERT_IMP(a_queue_order, clk, arst_n, 1'b1, head_q <= tail_q)
	`GBT_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sp_q <= SCW'(WALK_DEPTH))
endmodule
`default_nettype wire

// ===== tb/sv/graph_bfs_dfs_traversal_checker.sv =====
// ----------------------------------------------------------------------------
// Graph traversal checker
// Watches the command and result channels and the register port, predicts
// the result beats of every accepted command and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module graph_bfs_dfs_traversal_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire gbt_pkg::in_item_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire gbt_pkg::out_item_t out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	output int                      errors,
	output int                      pending
);
	import gbt_pkg::*;

	localparam int NV   = MAX_VERTICES_DEF;
	localparam int ND   = MAX_DEGREE_DEF;
	localparam int RING = 256;

	logic [VC_W-1:0]  count_reg;
	logic [VTX_W-1:0] adj [NV][ND];
	int               deg [NV];
	bit               seen [NV];
	out_item_t        expected_beats [RING];
	int               exp_wr = 0;
	int               exp_rd = 0;

	assign pending = exp_wr - exp_rd;

	// Appends one beat to the ring of expected results.
	function automatic void enqueue_beat(out_item_t r);
		expected_beats[exp_wr % RING] = r;
		exp_wr++;
	endfunction

	function automatic void push_status(status_t st);
		out_item_t r;
		r.vertex = '0;
		r.status = st;
		r.last   = 1'b1;
		enqueue_beat(r);
	endfunction

	function automatic void push_visit(logic [VTX_W-1:0] v);
		out_item_t r;
		r.vertex = v;
		r.status = ST_VISIT;
		r.last   = 1'b0;
		enqueue_beat(r);
	endfunction

	// Works out every result beat of one command and updates the graph copy.
	function automatic void predict_command(in_item_t c);
		int cnt, a, b, head, tail, n, sp, v, i, w;
		int fifo [32];
		int stk_v [32];
		int stk_i [32];
		cnt = (count_reg > NV) ? NV : count_reg;
		a = c.first_vertex;
		b = c.second_vertex;
		if (c.cmd == CMD_CLEAR) begin
			foreach (deg[k]) deg[k] = 0;
			push_status(ST_DONE);
			return;
		end
		if (c.cmd == CMD_ADD) begin
			if (a >= cnt || b >= cnt) begin
				push_status(ST_RANGE);
			end else if ((a == b && deg[a] + 2 > ND) ||
					(a != b && (deg[a] >= ND || deg[b] >= ND))) begin
				push_status(ST_FULL);
			end else begin
				adj[a][deg[a]] = VTX_W'(b);
				deg[a]++;
				adj[b][deg[b]] = VTX_W'(a);
				deg[b]++;
				push_status(ST_DONE);
			end
			return;
		end
		if (a >= cnt) begin
			push_status(ST_RANGE);
			return;
		end
		foreach (seen[k]) seen[k] = 0;
		seen[a] = 1;
		if (c.cmd == CMD_BFS) begin
			head = 0;
			tail = 1;
			fifo[0] = a;
			while (head < tail) begin
				v = fifo[head];
				head++;
				push_visit(VTX_W'(v));
				for (i = 0; i < deg[v]; i++) begin
					w = adj[v][i];
					if (w < cnt && !seen[w] && tail < 32) begin
						seen[w] = 1;
						fifo[tail] = w;
						tail++;
					end
				end
			end
		end else begin
			n = 1;
			push_visit(VTX_W'(a));
			sp = 1;
			stk_v[0] = a;
			stk_i[0] = 0;
			while (sp > 0) begin
				v = stk_v[sp-1];
				i = stk_i[sp-1];
				if (i >= deg[v]) begin
					sp--;
				end else begin
					stk_i[sp-1] = i + 1;
					w = adj[v][i];
					if (w < cnt && !seen[w] && sp < 32 && n < 32) begin
						seen[w] = 1;
						push_visit(VTX_W'(w));
						n++;
						stk_v[sp] = w;
						stk_i[sp] = 0;
						sp++;
					end
				end
			end
		end
		expected_beats[(exp_wr - 1) % RING].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			count_reg = VC_RESET;
			foreach (deg[k]) deg[k] = 0;
			foreach (seen[k]) seen[k] = 0;
			exp_wr = 0;
			exp_rd = 0;
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				count_reg = pwdata[VC_W-1:0];
			if (out_valid && out_ready) begin
				if (exp_wr == exp_rd) begin
					$error("unexpected result beat vertex=%0d status=%0d last=%0d",
						out_data.vertex, out_data.status, out_data.last);
					errors++;
				end else begin
					want = expected_beats[exp_rd % RING];
					exp_rd++;
					if (out_data.vertex !== want.vertex) begin
						$error("vertex: expected %0d, got %0d", want.vertex, out_data.vertex);
						errors++;
					end
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						errors++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_data.last);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_command(in_data);
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_graph_bfs_dfs_traversal.sv =====
// ----------------------------------------------------------------------------
// Graph traversal testbench
// Drives edge, walk and clear commands under several vertex counts and
// handshake pressures; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_graph_bfs_dfs_traversal;
	import gbt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          cycle_count = 0;

	// Percent chances of the sender idling and of the receiver stalling.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// With stalls on every beat, this limit still leaves a wide margin over
	// the whole run.
	localparam int CYCLE_LIMIT = 2000000;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	graph_bfs_dfs_traversal uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	graph_bfs_dfs_traversal_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	// The receiver stalls at random; a new decision is made on every edge.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("graph_bfs_dfs_traversal: mismatch");
			$finish;
		end
	end

	// Sends one command beat, with a random idle gap ahead of it, and holds
	// it until the block takes it. Valid drops only while the sender idles,
	// or when drain() is called after the last beat of a group.
	task automatic send_beat(cmd_t c, int a, int b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.cmd <= c;
		in_data.first_vertex <= a[4:0];
		in_data.second_vertex <= b[4:0];
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Waits until every predicted beat has come, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Register write through the setup and access cycles of the port.
	task automatic write_count(int value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Random command mix: mostly edges among low ids so that walks reach far,
	// a few clears so lists do not stay full, and some out-of-range ids.
	task automatic random_beats(int count, int span);
		int r;
		int lim;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			lim = (span > 1) ? span - 1 : 0;
			if (r < 55)
				send_beat(CMD_ADD,
					($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(lim),
					($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(lim));
			else if (r < 75)
				send_beat(CMD_BFS, $urandom_range(31), $urandom_range(31));
			else if (r < 95)
				send_beat(CMD_DFS, $urandom_range(31), $urandom_range(31));
			else
				send_beat(CMD_CLEAR, $urandom_range(31), $urandom_range(31));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes of the ids, both kinds of walk, self loops,
		// a full list and a clear.
		send_beat(CMD_ADD, 0, 31);
		send_beat(CMD_ADD, 31, 31);
		send_beat(CMD_ADD, 0, 1);
		send_beat(CMD_ADD, 1, 2);
		send_beat(CMD_ADD, 2, 0);
		send_beat(CMD_BFS, 0, 31);
		send_beat(CMD_DFS, 0, 0);
		send_beat(CMD_DFS, 31, 21);
		for (int k = 0; k < 8; k++)
			send_beat(CMD_ADD, 5, 6 + k);
		send_beat(CMD_ADD, 7, 7);
		send_beat(CMD_BFS, 5, 10);
		send_beat(CMD_DFS, 6, 0);
		send_beat(CMD_CLEAR, 31, 31);
		send_beat(CMD_BFS, 31, 0);
		drain();

		// A lowered count leaves longer lists in place; walks skip high ids.
		for (int k = 1; k < 8; k++)
			send_beat(CMD_ADD, 0, k * 4);
		drain();
		write_count(9);
		send_beat(CMD_BFS, 0, 0);
		send_beat(CMD_DFS, 0, 0);
		send_beat(CMD_ADD, 9, 1);
		send_beat(CMD_BFS, 20, 0);
		drain();

		// A count of 0 rejects every id; a count above capacity acts as 32.
		write_count(0);
		send_beat(CMD_ADD, 0, 0);
		send_beat(CMD_DFS, 0, 0);
		drain();
		write_count(63);
		send_beat(CMD_ADD, 31, 30);
		send_beat(CMD_BFS, 31, 0);
		drain();

		// Random part in four pressure phases and several counts.
		write_count(32);
		random_beats(90, 12);
		drain();
		send_idle_pct = 57;
		write_count(1);
		random_beats(15, 1);
		drain();
		write_count(16);
		random_beats(80, 16);
		// Hold off the sender until every result is back.
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 57;
		write_count(32);
		random_beats(90, 32);
		drain();
		send_idle_pct = 14;
		recv_stall_pct = 14;
		write_count(24);
		random_beats(90, 8);
		drain();

		if (errors == 0)
			$display("graph_bfs_dfs_traversal: match");
		else
			$display("graph_bfs_dfs_traversal: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/gbt_pkg.sv
sv/gbt_ram.sv
sv/gbt_cmp.sv
sv/graph_bfs_dfs_traversal.sv
tb/sv/graph_bfs_dfs_traversal_checker.sv
tb/sv/tb_graph_bfs_dfs_traversal.sv
